### sv/four_class_stable_priority_queue_defines.svh
// Assertion macros for the four-class stable priority queue.
// Included by four_class_stable_priority_queue.sv, which carries concurrent checks; no other dependencies.
`ifndef FOUR_CLASS_STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define FOUR_CLASS_STABLE_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTH
// Check a property on the rising clock edge, skipped while reset is high
`define FCSPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fcspq check failed");
// Check a property on the rising clock edge, reset included
`define FCSPQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fcspq check failed");
`else
`define FCSPQ_ASSERT(label, clk, rst, prop)
`define FCSPQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### sv/fcspq_pkg.sv
// Shared types and codes for the four-class stable priority queue.
// Used by fcspq_store and four_class_stable_priority_queue; no dependencies.
package fcspq_pkg;

  // Field widths of the request and result items
  localparam int REQ_W   = 2;
  localparam int CLASS_W = 3;
  localparam int AGE_W   = 7;
  localparam int TAG_W   = 16;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CALL  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // One stored entry: age over tag
  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

### sv/fcspq_store.sv
// Entry memory of the priority queue: one write port, one registered read port.
// Depends on fcspq_pkg for the entry type.
module fcspq_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  fcspq_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output fcspq_pkg::entry_t rd_data
);
  import fcspq_pkg::*;

  entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry; hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/four_class_stable_priority_queue.sv
// Four-class stable priority queue: one request in, one result out.
//
// Input channel (in_valid / in_stall) carries a request: req_type selects add,
// call head or clear; priority_class, entry_age and entry_tag describe an added
// item. Class 1 is most urgent; items of one class leave in arrival order.
// Output channel (out_valid / out_stall) carries one result per request:
// status, the served item's class, age and tag (zero unless a call served one),
// and the occupancy after the request.
// The block takes no new request until the result of the last one is loaded:
// the accept cycle updates the class pointers and issues the entry memory
// access; then in S_WAIT the block takes the registered memory read and
// loads the output register once it is free.
// When the receiver stalls, the result waits in the output register; one more
// request is taken and finished up to the memory read, then in_stall stays
// high until the output register frees.
// Reset (synchronous, active high) empties the queue and drops any pending
// result. The entry memory itself is not cleared; the class pointers track
// which slots hold entries.
// Depends on fcspq_pkg, fcspq_store and four_class_stable_priority_queue_defines.svh.
`include "four_class_stable_priority_queue_defines.svh"
module four_class_stable_priority_queue #(
  parameter int CAPACITY    = 64,
  parameter int NUM_CLASSES = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fcspq_pkg::REQ_W-1:0]     req_type,
  input  logic [fcspq_pkg::CLASS_W-1:0]   priority_class,
  input  logic [fcspq_pkg::AGE_W-1:0]     entry_age,
  input  logic [fcspq_pkg::TAG_W-1:0]     entry_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fcspq_pkg::STAT_W-1:0]    status,
  output logic [fcspq_pkg::CLASS_W-1:0]   served_class,
  output logic [fcspq_pkg::AGE_W-1:0]     served_age,
  output logic [fcspq_pkg::TAG_W-1:0]     served_tag,
  output logic [fcspq_pkg::OCC_W-1:0]     occupancy
);
  import fcspq_pkg::*;

  localparam int DEPTH = NUM_CLASSES * CAPACITY;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(CAPACITY);
  localparam int CNTW  = $clog2(CAPACITY + 1);
  localparam int CW    = $clog2(NUM_CLASSES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic state;
  logic state_next;

  logic [PW-1:0]   rptr  [NUM_CLASSES];
  logic [PW-1:0]   wptr  [NUM_CLASSES];
  logic [CNTW-1:0] count [NUM_CLASSES];
  logic [CNTW-1:0] total_count;

  // Result of the request in flight
  logic [STAT_W-1:0]  pend_status;
  logic               pend_call;
  logic [CLASS_W-1:0] pend_class;

  logic          in_acc;
  logic          out_load;
  logic [CW-1:0] add_c;
  logic [CW-1:0] head_c;
  logic          is_full;
  logic          is_empty;
  logic          do_add;
  logic          do_call;
  logic          do_clear;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  assign in_stall = (state == S_WAIT);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_WAIT) && (!out_valid || !out_stall);

  // Clamp the requested class into range
  always_comb begin
    if (priority_class == '0) begin
      add_c = '0;
    end else if (32'(priority_class) > NUM_CLASSES) begin
      add_c = CW'(NUM_CLASSES - 1);
    end else begin
      add_c = CW'(priority_class - CLASS_W'(1));
    end
  end

  // Find the most urgent class that holds entries
  always_comb begin
    head_c = CW'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        head_c = CW'(i);
      end
    end
  end

  assign is_full  = 32'(total_count) >= CAPACITY;
  assign is_empty = (total_count == '0);
  assign do_add   = in_acc && (req_type == REQ_ADD) && !is_full;
  assign do_call  = in_acc && (req_type == REQ_CALL) && !is_empty;
  assign do_clear = in_acc && (req_type == REQ_CLEAR) && !is_empty;

  // Memory access issued in the accept cycle
  assign wr_en   = do_add;
  assign wr_addr = AW'(add_c) * AW'(CAPACITY) + AW'(wptr[add_c]);
  assign wr_data = '{age: entry_age, tag: entry_tag};
  assign rd_en   = do_call;
  assign rd_addr = AW'(head_c) * AW'(CAPACITY) + AW'(rptr[head_c]);

  fcspq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Advance the class pointers and counts, or clear them on reset or clear
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        rptr[i]  <= '0;
        wptr[i]  <= '0;
        count[i] <= '0;
      end
      total_count <= '0;
    end else if (do_add) begin
      wptr[add_c]  <= (32'(wptr[add_c]) == CAPACITY - 1) ? '0 : wptr[add_c] + PW'(1);
      count[add_c] <= count[add_c] + CNTW'(1);
      total_count  <= total_count + CNTW'(1);
    end else if (do_call) begin
      rptr[head_c]  <= (32'(rptr[head_c]) == CAPACITY - 1) ? '0 : rptr[head_c] + PW'(1);
      count[head_c] <= count[head_c] - CNTW'(1);
      total_count   <= total_count - CNTW'(1);
    end
  end

  // Hold the status, call flag and served class of the accepted request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_call  <= do_call;
      pend_class <= CLASS_W'({1'b0, head_c} + (CW + 1)'(1));
      case (req_type) inside
        REQ_ADD:   pend_status <= is_full ? ST_FULL : ST_DONE;
        REQ_CALL,
        REQ_CLEAR: pend_status <= is_empty ? ST_EMPTY : ST_DONE;
        default:   pend_status <= ST_DONE;
      endcase
    end
  end

  // Sequence accept and result load
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_acc) state_next = S_WAIT;
      S_WAIT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= pend_status;
      served_class <= pend_call ? pend_class : '0;
      served_age   <= pend_call ? rd_data.age : '0;
      served_tag   <= pend_call ? rd_data.tag : '0;
      occupancy    <= OCC_W'(total_count);
    end
  end

  // Checks
  `FCSPQ_ASSERT(a_accept_to_wait, clk, rst, in_acc |=> (state == S_WAIT))
  `FCSPQ_ASSERT(a_result_after_wait, clk, rst, $rose(out_valid) |-> ($past(state) == S_WAIT))
  `FCSPQ_ASSERT(a_total_bounded, clk, rst, (32'(total_count) <= CAPACITY))
  `FCSPQ_ASSERT(a_call_takes_one, clk, rst, do_call |=> (total_count == $past(total_count) - CNTW'(1)))

endmodule
